>>> sv/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared codes, configuration and queue entry types of the binary16 ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_MAX  = 3'd4;
  localparam logic [2:0] OP_MIN  = 3'd5;
  localparam logic [2:0] OP_RSUB = 3'd6;
  localparam logic [2:0] OP_RDIV = 3'd7;

  localparam logic [1:0] BC_NONE = 2'd0;
  localparam logic [1:0] BC_B    = 2'd1;
  localparam logic [1:0] BC_A    = 2'd2;

  localparam logic [1:0] REG_OPERATION = 2'd0;
  localparam logic [1:0] REG_BROADCAST = 2'd1;
  localparam logic [1:0] REG_SCALAR    = 2'd2;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_MUL = 2'd1;
  localparam logic [1:0] KIND_DIV = 2'd2;

  localparam logic [15:0] DEFAULT_NAN = 16'h7E00;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  broadcast_mode;
    logic [15:0] scalar_operand;
  } cfg_t;

  typedef struct packed {
    logic        last;
    logic        special;
    logic [15:0] sval;
    logic [1:0]  kind;
    logic        xs;
    logic        ys;
    logic [14:0] xm;
    logic [14:0] ym;
  } fq_t;

endpackage

>>> sv/fpalu_front.sv
// ----------------------------------------------------------------------------
// fpalu_front
// Input register and classifier: broadcast, operand order, NaN, infinity,
// zero and max/min results, and the arithmetic kind for the back end.
// ----------------------------------------------------------------------------
module fpalu_front import fpalu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // a_value [15:0], b_value [31:16]
  input  logic        s_tlast,
  input  logic        q_full,
  output logic        push,
  output fq_t         entry
);

  logic        vld;
  logic [15:0] a_reg;
  logic [15:0] b_reg;
  logic        last_reg;

  logic [15:0] a, b, x, y, yf;
  logic        swap, sub;
  logic        xnan, ynan, xsnan, ysnan, xinf, yinf, xz, yz, gt, eq;

  assign push     = vld && !q_full;
  assign s_tready = !vld || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_tready) begin
      vld <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      a_reg    <= s_tdata[15:0];
      b_reg    <= s_tdata[31:16];
      last_reg <= s_tlast;
    end
  end

  always_comb begin
    a = a_reg;
    b = b_reg;
    if (cfg.broadcast_mode == BC_B) begin
      b = cfg.scalar_operand;
    end else if (cfg.broadcast_mode == BC_A) begin
      a = cfg.scalar_operand;
    end
    swap = (cfg.operation == OP_RSUB) || (cfg.operation == OP_RDIV);
    sub  = (cfg.operation == OP_SUB) || (cfg.operation == OP_RSUB);
    x    = swap ? b : a;
    y    = swap ? a : b;
    yf   = {y[15] ^ sub, y[14:0]};

    xnan  = (&x[14:10]) && (|x[9:0]);
    ynan  = (&y[14:10]) && (|y[9:0]);
    xsnan = xnan && !x[9];
    ysnan = ynan && !y[9];
    xinf  = (&x[14:10]) && !(|x[9:0]);
    yinf  = (&y[14:10]) && !(|y[9:0]);
    xz    = (x[14:0] == 15'd0);
    yz    = (y[14:0] == 15'd0);

    eq = (x == y) || (xz && yz);
    if (x[15] != y[15]) begin
      gt = !x[15];
    end else if (!x[15]) begin
      gt = x[14:0] > y[14:0];
    end else begin
      gt = x[14:0] < y[14:0];
    end

    entry.last    = last_reg;
    entry.special = 1'b0;
    entry.sval    = 16'd0;
    entry.xs      = x[15];
    entry.ys      = yf[15];
    entry.xm      = x[14:0];
    entry.ym      = y[14:0];
    case (cfg.operation)
      OP_MUL:            entry.kind = KIND_MUL;
      OP_DIV, OP_RDIV:   entry.kind = KIND_DIV;
      default:           entry.kind = KIND_ADD;
    endcase

    if (xsnan) begin
      entry.special = 1'b1;
      entry.sval    = x | 16'h0200;
    end else if (ysnan) begin
      entry.special = 1'b1;
      entry.sval    = y | 16'h0200;
    end else if (xnan) begin
      entry.special = 1'b1;
      entry.sval    = x;
    end else if (ynan) begin
      entry.special = 1'b1;
      entry.sval    = y;
    end else begin
      case (cfg.operation)
        OP_MAX: begin
          entry.special = 1'b1;
          entry.sval    = eq ? (x & y) : (gt ? x : y);
        end
        OP_MIN: begin
          entry.special = 1'b1;
          entry.sval    = eq ? (x | y) : (gt ? y : x);
        end
        OP_MUL: begin
          if ((xinf && yz) || (xz && yinf)) begin
            entry.special = 1'b1;
            entry.sval    = DEFAULT_NAN;
          end else if (xinf || yinf) begin
            entry.special = 1'b1;
            entry.sval    = {x[15] ^ y[15], 15'h7C00};
          end
        end
        OP_DIV, OP_RDIV: begin
          if ((xz && yz) || (xinf && yinf)) begin
            entry.special = 1'b1;
            entry.sval    = DEFAULT_NAN;
          end else if (yz || xinf) begin
            entry.special = 1'b1;
            entry.sval    = {x[15] ^ y[15], 15'h7C00};
          end else if (yinf || xz) begin
            entry.special = 1'b1;
            entry.sval    = {x[15] ^ y[15], 15'h0000};
          end
        end
        default: begin
          if (xinf && yinf && (x[15] != yf[15])) begin
            entry.special = 1'b1;
            entry.sval    = DEFAULT_NAN;
          end else if (xinf) begin
            entry.special = 1'b1;
            entry.sval    = x;
          end else if (yinf) begin
            entry.special = 1'b1;
            entry.sval    = yf;
          end
        end
      endcase
    end
  end

endmodule

>>> sv/fpalu_queue.sv
// ----------------------------------------------------------------------------
// fpalu_queue
// Small FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module fpalu_queue import fpalu_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  fq_t                        din,
  input  logic                       pop,
  output fq_t                        dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fq_t           mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

>>> sv/fpalu_back.sv
// ----------------------------------------------------------------------------
// fpalu_back
// Arithmetic pipeline: operand prep, align and add, two-bit-per-stage
// restoring divide, normalize, denormalize with sticky, round and pack.
// ----------------------------------------------------------------------------
module fpalu_back import fpalu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  fq_t         q_dout,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // result_value [15:0]
  output logic        m_tlast
);

  localparam int DIV_STAGES = 7;
  localparam int S_DIV_LAST = 1 + DIV_STAGES;
  localparam int S_ZERO     = S_DIV_LAST + 1;
  localparam int S_NORM     = S_ZERO + 1;
  localparam int S_DENORM   = S_NORM + 1;
  localparam int NS         = S_DENORM + 1;

  typedef struct packed {
    logic        last;
    logic        special;
    logic [15:0] sval;
    logic [1:0]  kind;
    logic        sign;
    logic        sub;
    logic [8:0]  ea;
    logic [8:0]  eb;
    logic [23:0] ma;
    logic [10:0] mb;
    logic [13:0] quo;
    logic        sticky;
    logic [4:0]  lz;
    logic [10:0] q11;
    logic        g;
    logic [6:0]  bem1;
  } bk_t;

  bk_t         stg [1:NS];
  bk_t         nx  [1:NS];
  logic [NS:1] vld;
  logic        adv;

  function automatic logic [3:0] lzc11(input logic [10:0] v);
    logic [3:0] n;
    n = 4'd11;
    for (int i = 0; i < 11; i++) begin
      if (v[i]) n = 4'(10 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic bk_t prep(input fq_t e);
    bk_t        n;
    logic [4:0] ex, ey;
    logic [10:0] sx, sy;
    logic [3:0] lx, ly;
    logic       xbig;
    n         = '0;
    n.last    = e.last;
    n.special = e.special;
    n.sval    = e.sval;
    n.kind    = e.kind;
    ex   = (e.xm[14:10] == 5'd0) ? 5'd1 : e.xm[14:10];
    ey   = (e.ym[14:10] == 5'd0) ? 5'd1 : e.ym[14:10];
    sx   = {e.xm[14:10] != 5'd0, e.xm[9:0]};
    sy   = {e.ym[14:10] != 5'd0, e.ym[9:0]};
    lx   = lzc11(sx);
    ly   = lzc11(sy);
    xbig = e.xm >= e.ym;
    case (e.kind)
      KIND_MUL: begin
        n.sign = e.xs ^ e.ys;
        n.ma   = 24'(sx * sy);
        n.ea   = 9'(ex) + 9'(ey) - 9'd50;
      end
      KIND_DIV: begin
        n.sign = e.xs ^ e.ys;
        n.ma   = 24'(sx << lx);
        n.mb   = sy << ly;
        n.ea   = 9'(ex) - 9'(lx) - 9'(ey) + 9'(ly) - 9'd13;
      end
      default: begin
        n.sign = xbig ? e.xs : e.ys;
        n.sub  = e.xs ^ e.ys;
        n.ma   = 24'(xbig ? sx : sy);
        n.mb   = xbig ? sy : sx;
        n.ea   = 9'(xbig ? ex : ey);
        n.eb   = xbig ? 9'(ex - ey) : 9'(ey - ex);
      end
    endcase
    return n;
  endfunction

  function automatic bk_t add_step(input bk_t p);
    bk_t         n;
    logic [13:0] ext, sh, le, se;
    logic        lost;
    logic [14:0] sum;
    n   = p;
    ext = {p.mb, 3'b000};
    if (p.eb >= 9'd14) begin
      sh   = 14'd0;
      lost = |p.mb;
    end else begin
      sh   = ext >> p.eb[3:0];
      lost = |(ext & ~(14'h3FFF << p.eb[3:0]));
    end
    se  = {sh[13:1], sh[0] | lost};
    le  = {p.ma[10:0], 3'b000};
    sum = p.sub ? ({1'b0, le} - {1'b0, se}) : ({1'b0, le} + {1'b0, se});
    n.ma = 24'(sum);
    n.ea = p.ea - 9'd28;
    if (sum == 15'd0) begin
      n.sign = p.sign & ~p.sub;
    end
    return n;
  endfunction

  function automatic bk_t div_step(input bk_t p, input logic fin);
    bk_t         n;
    logic [11:0] r;
    logic [13:0] q;
    logic        bit_q;
    n = p;
    r = p.ma[11:0];
    q = p.quo;
    for (int i = 0; i < 2; i++) begin
      bit_q = r >= {1'b0, p.mb};
      if (bit_q) r = r - {1'b0, p.mb};
      q = {q[12:0], bit_q};
      r = {r[10:0], 1'b0};
    end
    n.quo = q;
    if (fin) begin
      n.ma     = 24'(q);
      n.sticky = (r != 12'd0);
    end else begin
      n.ma = 24'(r);
    end
    return n;
  endfunction

  function automatic bk_t zero_step(input bk_t p);
    bk_t n;
    n    = p;
    n.lz = lzc24(p.ma);
    if (!p.special && (p.ma == 24'd0) && !p.sticky) begin
      n.special = 1'b1;
      n.sval    = {p.sign, 15'd0};
    end
    return n;
  endfunction

  function automatic bk_t norm_step(input bk_t p);
    bk_t n;
    n    = p;
    n.ma = p.ma << p.lz;
    n.ea = p.ea - 9'(p.lz);
    return n;
  endfunction

  function automatic bk_t denorm_step(input bk_t p);
    bk_t         n;
    logic        clamp;
    logic [8:0]  shv;
    logic [11:0] t;
    logic        lost;
    n     = p;
    clamp = $signed(p.ea) < -9'sd37;
    shv   = clamp ? (9'h1E7 - p.ea) : 9'd12;
    if (shv >= 9'd24) begin
      t    = 12'd0;
      lost = |p.ma;
    end else begin
      t    = 12'(p.ma >> shv[4:0]);
      lost = |(p.ma & ~(24'hFFFFFF << shv[4:0]));
    end
    n.q11    = t[11:1];
    n.g      = t[0];
    n.sticky = lost | p.sticky;
    n.bem1   = clamp ? 7'd0 : 7'(p.ea + 9'd37);
    return n;
  endfunction

  function automatic bk_t round_step(input bk_t p);
    bk_t         n;
    logic [11:0] qr;
    logic [16:0] val;
    n   = p;
    qr  = {1'b0, p.q11} + 12'(p.g & (p.sticky | p.q11[0]));
    val = {p.bem1, 10'd0} + 17'(qr);
    if (!p.special) begin
      n.sval = (val >= 17'h07C00) ? {p.sign, 15'h7C00} : {p.sign, val[14:0]};
    end
    return n;
  endfunction

  assign adv      = !vld[NS] || m_tready;
  assign pop      = adv && !q_empty;
  assign m_tvalid = vld[NS];
  assign m_tdata  = stg[NS].sval;
  assign m_tlast  = stg[NS].last;

  always_comb begin
    nx[1] = prep(q_dout);
    case (stg[1].kind)
      KIND_ADD: nx[2] = add_step(stg[1]);
      KIND_DIV: nx[2] = div_step(stg[1], 1'b0);
      default:  nx[2] = stg[1];
    endcase
    for (int i = 3; i <= S_DIV_LAST; i++) begin
      nx[i] = (stg[i-1].kind == KIND_DIV) ? div_step(stg[i-1], i == S_DIV_LAST) : stg[i-1];
    end
    nx[S_ZERO]   = zero_step(stg[S_DIV_LAST]);
    nx[S_NORM]   = norm_step(stg[S_ZERO]);
    nx[S_DENORM] = denorm_step(stg[S_NORM]);
    nx[NS]       = round_step(stg[S_DENORM]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-1:1], pop};
    end
    if (adv) begin
      for (int i = 1; i <= NS; i++) begin
        stg[i] <= nx[i];
      end
    end
  end

endmodule

>>> sv/fp16_elementwise_binary_alu.sv
// ----------------------------------------------------------------------------
// fp16_elementwise_binary_alu
// Elementwise IEEE binary16 add, subtract, multiply, divide, max and min.
// ----------------------------------------------------------------------------
// Operands arrive on the s_ stream: tdata holds a_value in the low half and
// b_value in the high half, tlast marks the final element of a vector. Each
// request gives one result on the m_ stream, result_value in tdata and the
// copied marker in tlast, in request order.
// The cfg channel writes operation, broadcast_mode and scalar_operand by
// index; it is always ready and should only be used while the block is idle.
// Throughput is one element per cycle while the receiver accepts results. An
// accepted request passes through one input register, one queue slot, one
// operand prep stage, seven stages of a two-bit-per-stage divider that the
// other operations pass through, and four normalize and round stages.
// When the receiver stalls, the whole pipeline holds; the queue then fills
// and s_tready drops once it is full. Reset clears the registers to add, no
// broadcast and a zero scalar, and empties the pipeline and the queue.
// ----------------------------------------------------------------------------
module fp16_elementwise_binary_alu import fpalu_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // a_value [15:0], b_value [31:16]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // result_value [15:0]
  output logic        m_tlast
);

  cfg_t                        cfg;
  logic                        push, pop, q_full, q_empty;
  fq_t                         q_din, q_dout;
  logic [$clog2(QDEPTH+1)-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OPERATION: cfg.operation      <= cfg_data[2:0];
        REG_BROADCAST: cfg.broadcast_mode <= cfg_data[1:0];
        REG_SCALAR:    cfg.scalar_operand <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fpalu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .entry    (q_din)
  );

  fpalu_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .pop   (pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  fpalu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_dout   (q_dout),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(QDEPTH+1))'(QDEPTH))
    else $error("queue count exceeds its depth");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_full)
    else $error("input stalled while the queue has room");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule
